// ===== design/madt_pkg.sv =====
// Shared constants and types of the MADT I/O APIC and IRQ override parser.
`default_nettype none
package madt_pkg;

    // Parameter defaults
    localparam int LEGACY_IRQS_DEF         = 16;
    localparam int RECORD_BUFFER_BYTES_DEF = 12;

    // Table layout
    localparam logic [31:0] FIRST_RECORD  = 32'd44;
    localparam logic [31:0] LEN_FIELD_END = 32'd8;
    localparam logic [31:0] REC_HDR_BYTES = 32'd2;

    // Record types and minimum lengths
    localparam logic [7:0] REC_IOAPIC       = 8'd1;
    localparam logic [7:0] REC_OVERRIDE     = 8'd2;
    localparam logic [7:0] IOAPIC_MIN_LEN   = 8'd12;
    localparam logic [7:0] OVERRIDE_MIN_LEN = 8'd10;
    localparam logic [7:0] REC_MIN_LEN      = 8'd2;

    // Job queue between parser and row emitter
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Per-run summary handed from parser to row emitter
    typedef struct packed {
        logic        status;
        logic        short_tbl;
        logic [7:0]  io_apic_id;
        logic [31:0] io_apic_address;
        logic [31:0] io_apic_interrupt_base;
    } job_hdr_t;

endpackage : madt_pkg
`default_nettype wire

// ===== design/madt_io_apic_irq_override_parser.sv =====
// Top level: MADT parser, job queue and row emitter.
// The final byte's beat writes the job queue; rows then load into the output register.
// Rate: a byte per cycle if not full; rows one per cycle on pop, LEGACY_IRQS per run.
// full rises only while two runs wait in the job queue (one still emitting rows).
// Reset: parser returns to the start of a table, queue and output register empty.
// Reset needs no clearing pass; the block takes bytes on the first cycle after reset.
`default_nettype none
module madt_io_apic_irq_override_parser #(
    parameter int LEGACY_IRQS         = madt_pkg::LEGACY_IRQS_DEF,
    parameter int RECORD_BUFFER_BYTES = madt_pkg::RECORD_BUFFER_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  table_byte,
    input  wire         first_byte,
    input  wire         final_byte,
    input  wire  [7:0]  wanted_index,
    output logic        empty,
    input  wire         pop,
    output logic        status,
    output logic [7:0]  io_apic_id,
    output logic [31:0] io_apic_address,
    output logic [31:0] io_apic_interrupt_base,
    output logic [3:0]  irq_line,
    output logic [31:0] irq_global_interrupt,
    output logic [15:0] irq_flags,
    output logic        last_row
);
    import madt_pkg::*;

    logic        in_acc;
    logic        job_valid;
    job_hdr_t    job_hdr;
    logic [31:0] job_gsi    [LEGACY_IRQS];
    logic [15:0] job_flags  [LEGACY_IRQS];
    logic        head_valid;
    job_hdr_t    head_hdr;
    logic [31:0] head_gsi   [LEGACY_IRQS];
    logic [15:0] head_flags [LEGACY_IRQS];
    logic        job_done;
    logic        q_full;
    logic        out_pop;

    // Beat acceptance
    assign in_acc  = push && !q_full;
    assign full    = q_full;
    assign out_pop = pop && !empty;

    madt_front #(
        .LEGACY_IRQS        (LEGACY_IRQS),
        .RECORD_BUFFER_BYTES(RECORD_BUFFER_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_acc      (in_acc),
        .table_byte  (table_byte),
        .first_byte  (first_byte),
        .final_byte  (final_byte),
        .wanted_index(wanted_index),
        .job_valid   (job_valid),
        .job_hdr     (job_hdr),
        .job_gsi     (job_gsi),
        .job_flags   (job_flags)
    );

    madt_jobq #(
        .LEGACY_IRQS(LEGACY_IRQS)
    ) u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_valid),
        .wr_hdr    (job_hdr),
        .wr_gsi    (job_gsi),
        .wr_flags  (job_flags),
        .rd_en     (job_done),
        .full      (q_full),
        .head_valid(head_valid),
        .head_hdr  (head_hdr),
        .head_gsi  (head_gsi),
        .head_flags(head_flags)
    );

    madt_back #(
        .LEGACY_IRQS(LEGACY_IRQS)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .head_valid            (head_valid),
        .head_hdr              (head_hdr),
        .head_gsi              (head_gsi),
        .head_flags            (head_flags),
        .job_done              (job_done),
        .pop                   (out_pop),
        .empty                 (empty),
        .status                (status),
        .io_apic_id            (io_apic_id),
        .io_apic_address       (io_apic_address),
        .io_apic_interrupt_base(io_apic_interrupt_base),
        .irq_line              (irq_line),
        .irq_global_interrupt  (irq_global_interrupt),
        .irq_flags             (irq_flags),
        .last_row              (last_row)
    );

endmodule : madt_io_apic_irq_override_parser
`default_nettype wire

// ===== design/madt_front.sv =====
// Byte parser: table length, record walk, chosen I/O APIC and override table.
`default_nettype none
module madt_front #(
    parameter int LEGACY_IRQS         = madt_pkg::LEGACY_IRQS_DEF,
    parameter int RECORD_BUFFER_BYTES = madt_pkg::RECORD_BUFFER_BYTES_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_acc,
    input  wire  [7:0]            table_byte,
    input  wire                   first_byte,
    input  wire                   final_byte,
    input  wire  [7:0]            wanted_index,
    output logic                  job_valid,
    output madt_pkg::job_hdr_t    job_hdr,
    output logic [31:0]           job_gsi   [LEGACY_IRQS],
    output logic [15:0]           job_flags [LEGACY_IRQS]
);
    import madt_pkg::*;

    logic [31:0] pos_reg,    pos_next;
    logic [31:0] tlen_reg,   tlen_next;
    logic [31:0] rstart_reg, rstart_next;
    logic [7:0]  rtype_reg,  rtype_next;
    logic [7:0]  rlen_reg,   rlen_next;
    logic        stop_reg,   stop_next;
    logic [7:0]  seen_reg,   seen_next;
    logic [7:0]  target_reg, target_next;
    logic        found_reg,  found_next;
    logic [7:0]  id_reg,     id_next;
    logic [31:0] addr_reg,   addr_next;
    logic [31:0] base_reg,   base_next;
    logic [31:0] ov_gsi_reg   [LEGACY_IRQS];
    logic [31:0] ov_gsi_next  [LEGACY_IRQS];
    logic [15:0] ov_flags_reg [LEGACY_IRQS];
    logic [15:0] ov_flags_next[LEGACY_IRQS];
    logic [7:0]  rb_reg  [RECORD_BUFFER_BYTES];
    logic [7:0]  rb_next [RECORD_BUFFER_BYTES];

    logic [31:0] p;
    logic [31:0] off;
    logic [31:0] room;
    logic        go;
    logic        short_tbl;

    function automatic logic [31:0] le32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3);
        le32 = {b3, b2, b1, b0};
    endfunction

    // Per-beat parse step
    always_comb
    begin
        pos_next    = pos_reg;
        tlen_next   = tlen_reg;
        rstart_next = rstart_reg;
        rtype_next  = rtype_reg;
        rlen_next   = rlen_reg;
        stop_next   = stop_reg;
        seen_next   = seen_reg;
        target_next = target_reg;
        found_next  = found_reg;
        id_next     = id_reg;
        addr_next   = addr_reg;
        base_next   = base_reg;
        ov_gsi_next   = ov_gsi_reg;
        ov_flags_next = ov_flags_reg;
        rb_next     = rb_reg;
        p    = '0;
        off  = '0;
        room = '0;
        go   = 1'b0;
        if (in_acc)
        begin
            // first byte restarts the table
            if (first_byte)
            begin
                pos_next    = '0;
                tlen_next   = '0;
                rstart_next = FIRST_RECORD;
                rtype_next  = '0;
                rlen_next   = '0;
                stop_next   = 1'b0;
                seen_next   = '0;
                target_next = wanted_index;
                found_next  = 1'b0;
                id_next     = '0;
                addr_next   = '0;
                base_next   = '0;
                for (int i = 0; i < LEGACY_IRQS; i++)
                begin
                    ov_gsi_next[i]   = 32'(i);
                    ov_flags_next[i] = '0;
                end
            end
            p = pos_next;
            if (pos_next != '1)
            begin
                pos_next = pos_next + 32'd1;
            end
            if (p inside {[32'd4:32'd7]})
            begin
                // little-endian length field
                tlen_next = tlen_next | (32'(table_byte) << {p[1:0], 3'b000});
            end
            else if (p >= FIRST_RECORD && p < tlen_next && tlen_next >= FIRST_RECORD
                     && !stop_next && p >= rstart_next)
            begin
                off  = p - rstart_next;
                room = tlen_next - rstart_next;
                go   = 1'b1;
                if (off == 32'd0)
                begin
                    if (room < REC_HDR_BYTES)
                    begin
                        stop_next = 1'b1;
                        go        = 1'b0;
                    end
                    else
                    begin
                        rtype_next = table_byte;
                    end
                end
                else if (off == 32'd1)
                begin
                    rlen_next = table_byte;
                    if (table_byte < REC_MIN_LEN || 32'(table_byte) > room)
                    begin
                        stop_next = 1'b1;
                        go        = 1'b0;
                    end
                end
                if (go)
                begin
                    for (int k = 0; k < RECORD_BUFFER_BYTES; k++)
                    begin
                        if (off == 32'(k))
                        begin
                            rb_next[k] = table_byte;
                        end
                    end
                    // last byte of the record: apply it
                    if (off != 32'd0 && off == 32'(rlen_next) - 32'd1)
                    begin
                        if (rtype_next == REC_IOAPIC && rlen_next >= IOAPIC_MIN_LEN)
                        begin
                            if (!found_next && seen_next == target_next)
                            begin
                                id_next    = rb_next[2];
                                addr_next  = le32(rb_next[4], rb_next[5], rb_next[6], rb_next[7]);
                                base_next  = le32(rb_next[8], rb_next[9], rb_next[10], rb_next[11]);
                                found_next = 1'b1;
                            end
                            if (seen_next != 8'hFF)
                            begin
                                seen_next = seen_next + 8'd1;
                            end
                        end
                        else if (rtype_next == REC_OVERRIDE && rlen_next >= OVERRIDE_MIN_LEN)
                        begin
                            for (int i = 0; i < LEGACY_IRQS; i++)
                            begin
                                if (rb_next[3] == 8'(i))
                                begin
                                    ov_gsi_next[i]   = le32(rb_next[4], rb_next[5],
                                                            rb_next[6], rb_next[7]);
                                    ov_flags_next[i] = {rb_next[9], rb_next[8]};
                                end
                            end
                        end
                        rstart_next = rstart_next + 32'(rlen_next);
                    end
                end
            end
        end
    end

    // Job snapshot on the final beat
    always_comb
    begin
        short_tbl = (pos_next < LEN_FIELD_END) || (tlen_next < FIRST_RECORD);
        job_valid = in_acc && final_byte;
        job_hdr.status                 = !(!short_tbl && found_next);
        job_hdr.short_tbl              = short_tbl;
        job_hdr.io_apic_id             = id_next;
        job_hdr.io_apic_address        = addr_next;
        job_hdr.io_apic_interrupt_base = base_next;
        job_gsi   = ov_gsi_next;
        job_flags = ov_flags_next;
    end

    // Control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tlen_reg   <= '0;
            rstart_reg <= FIRST_RECORD;
            rtype_reg  <= '0;
            rlen_reg   <= '0;
            stop_reg   <= 1'b0;
            seen_reg   <= '0;
            target_reg <= '0;
            found_reg  <= 1'b0;
            id_reg     <= '0;
            addr_reg   <= '0;
            base_reg   <= '0;
            for (int i = 0; i < LEGACY_IRQS; i++)
            begin
                ov_gsi_reg[i]   <= 32'(i);
                ov_flags_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg    <= pos_next;
            tlen_reg   <= tlen_next;
            rstart_reg <= rstart_next;
            rtype_reg  <= rtype_next;
            rlen_reg   <= rlen_next;
            stop_reg   <= stop_next;
            seen_reg   <= seen_next;
            target_reg <= target_next;
            found_reg  <= found_next;
            id_reg     <= id_next;
            addr_reg   <= addr_next;
            base_reg   <= base_next;
            ov_gsi_reg   <= ov_gsi_next;
            ov_flags_reg <= ov_flags_next;
        end
    end

    // Record byte buffer, no reset
    always_ff @(posedge clk)
    begin
        rb_reg <= rb_next;
    end

    // A stopped walk stays stopped until a new table starts
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg && !(in_acc && first_byte) |=> stop_reg)
        else $error("walk restarted without first byte");

endmodule : madt_front
`default_nettype wire

// ===== design/madt_jobq.sv =====
// Two-entry queue of row-run snapshots between parser and row emitter.
`default_nettype none
module madt_jobq #(
    parameter int LEGACY_IRQS = madt_pkg::LEGACY_IRQS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   wr_en,
    input  madt_pkg::job_hdr_t    wr_hdr,
    input  wire  [31:0]           wr_gsi   [LEGACY_IRQS],
    input  wire  [15:0]           wr_flags [LEGACY_IRQS],
    input  wire                   rd_en,
    output logic                  full,
    output logic                  head_valid,
    output madt_pkg::job_hdr_t    head_hdr,
    output logic [31:0]           head_gsi   [LEGACY_IRQS],
    output logic [15:0]           head_flags [LEGACY_IRQS]
);
    import madt_pkg::*;

    job_hdr_t     q_hdr_reg   [Q_DEPTH];
    logic [31:0]  q_gsi_reg   [Q_DEPTH][LEGACY_IRQS];
    logic [15:0]  q_flags_reg [Q_DEPTH][LEGACY_IRQS];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg,    cnt_next;

    // Pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
        head_valid = (cnt_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_hdr_reg[wr_ptr_reg]   <= wr_hdr;
            q_gsi_reg[wr_ptr_reg]   <= wr_gsi;
            q_flags_reg[wr_ptr_reg] <= wr_flags;
        end
    end

    // Head entry
    always_comb
    begin
        head_hdr   = q_hdr_reg[rd_ptr_reg];
        head_gsi   = q_gsi_reg[rd_ptr_reg];
        head_flags = q_flags_reg[rd_ptr_reg];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("job queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full || rd_en)
        else $error("job queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> head_valid)
        else $error("job queue underflow");

endmodule : madt_jobq
`default_nettype wire

// ===== design/madt_back.sv =====
// Row emitter: walks the head job into an output register, one legacy IRQ per cycle while rows are popped.
`default_nettype none
module madt_back #(
    parameter int LEGACY_IRQS = madt_pkg::LEGACY_IRQS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   head_valid,
    input  madt_pkg::job_hdr_t    head_hdr,
    input  wire  [31:0]           head_gsi   [LEGACY_IRQS],
    input  wire  [15:0]           head_flags [LEGACY_IRQS],
    output logic                  job_done,
    input  wire                   pop,
    output logic                  empty,
    output logic                  status,
    output logic [7:0]            io_apic_id,
    output logic [31:0]           io_apic_address,
    output logic [31:0]           io_apic_interrupt_base,
    output logic [3:0]            irq_line,
    output logic [31:0]           irq_global_interrupt,
    output logic [15:0]           irq_flags,
    output logic                  last_row
);
    import madt_pkg::*;

    localparam int IRQ_W = (LEGACY_IRQS > 1) ? $clog2(LEGACY_IRQS) : 1;
    localparam logic [IRQ_W-1:0] LAST_IDX = IRQ_W'(LEGACY_IRQS - 1);

    logic [IRQ_W-1:0] row_cnt_reg, row_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             load;
    logic             is_last;
    logic [IRQ_W+3:0] line_ext;

    job_hdr_t         hdr_reg;
    logic [3:0]       line_reg;
    logic [31:0]      gsi_reg;
    logic [15:0]      flags_reg;
    logic             last_reg;

    // Row sequencing
    always_comb
    begin
        load     = head_valid && (!out_valid_reg || pop);
        is_last  = (row_cnt_reg == LAST_IDX);
        job_done = load && is_last;
        line_ext = {4'b0000, row_cnt_reg};
        row_cnt_next = row_cnt_reg;
        if (load)
        begin
            row_cnt_next = is_last ? '0 : row_cnt_reg + 1'b1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output row register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg   <= head_hdr;
            line_reg  <= line_ext[3:0];
            gsi_reg   <= head_hdr.short_tbl ? '0 : head_gsi[row_cnt_reg];
            flags_reg <= head_hdr.short_tbl ? '0 : head_flags[row_cnt_reg];
            last_reg  <= is_last;
        end
    end

    always_comb
    begin
        empty                  = !out_valid_reg;
        status                 = hdr_reg.status;
        io_apic_id             = hdr_reg.io_apic_id;
        io_apic_address        = hdr_reg.io_apic_address;
        io_apic_interrupt_base = hdr_reg.io_apic_interrupt_base;
        irq_line               = line_reg;
        irq_global_interrupt   = gsi_reg;
        irq_flags              = flags_reg;
        last_row               = last_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> row_cnt_reg == '0)
        else $error("last row shown with run unfinished");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_done |-> load && head_valid)
        else $error("job retired without loading its last row");

endmodule : madt_back
`default_nettype wire
